// File: sv/balsm_pkg.sv
// ----------------------------------------------------------------------------
// balsm_pkg
// shared types and constants of the byte addressed load/store memory unit
// ----------------------------------------------------------------------------
package balsm_pkg;

   localparam int DATA_W               = 32;
   localparam int BYTE_W               = 8;
   localparam int BYTE_LANES           = 4;
   localparam int LANE_SEL_W           = 2;
   localparam int OP_W                 = 3;
   localparam int STATUS_W             = 2;
   localparam int HALF_W               = 16;
   localparam int MEMORY_WORDS_DEFAULT = 4096;

   typedef enum logic [OP_W-1:0] {
      OP_LB  = 3'd0,
      OP_LBU = 3'd1,
      OP_LH  = 3'd2,
      OP_LW  = 3'd3,
      OP_SB  = 3'd4,
      OP_SW  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_ALIGN = 2'd2
   } status_type;

   // what the load formatter needs to know about one access
   typedef struct packed {
      op_type                 op;
      logic [LANE_SEL_W-1:0]  lane;
      status_type             status;
   } access_type;

endpackage

// File: sv/balsm_if.sv
// ----------------------------------------------------------------------------
// balsm_req_if / balsm_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface balsm_req_if;
   logic                               valid;
   logic                               ready;
   logic [balsm_pkg::OP_W-1:0]         req_type;
   logic [balsm_pkg::DATA_W-1:0]       base_address;
   logic signed [balsm_pkg::DATA_W-1:0] offset;
   logic signed [balsm_pkg::DATA_W-1:0] store_data;

   modport source (output valid, req_type, base_address, offset, store_data, input ready);
   modport sink   (input valid, req_type, base_address, offset, store_data, output ready);
endinterface

interface balsm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [balsm_pkg::DATA_W-1:0] load_data;
   logic [balsm_pkg::STATUS_W-1:0]     status;

   modport source (output valid, load_data, status, input ready);
   modport sink   (input valid, load_data, status, output ready);
endinterface

// File: sv/byte_addressed_load_store_memory_unit.sv
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory_unit
// word organised data memory with byte addressing and rv32i style loads/stores
// ----------------------------------------------------------------------------
// One request transfer can be taken every cycle while the request register has
// room, and each gives exactly one response transfer, in order, after passing
// the request register, then the memory's registered read port, then the
// response register. The memory is four byte-wide rams of
// MEMORY_WORDS entries, one per byte lane, so a byte store touches only its
// lane. Each stage holds its transfer while the one after it is full, so up to
// three transfers may be in flight. The memory is not cleared after reset;
// reading a location never stored to returns arbitrary data.
// ----------------------------------------------------------------------------
module byte_addressed_load_store_memory_unit #(
   parameter int MEMORY_WORDS = balsm_pkg::MEMORY_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   balsm_req_if.sink   req_bus,
   balsm_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(MEMORY_WORDS);

   // stage enables, each stage moves when the next one has room
   logic en1;
   logic en2;
   logic en3;

   // request register
   logic                             v1_ff;
   logic [balsm_pkg::OP_W-1:0]       op1_ff;
   logic [balsm_pkg::DATA_W-1:0]     base1_ff;
   logic [balsm_pkg::DATA_W-1:0]     offset1_ff;
   logic [balsm_pkg::DATA_W-1:0]     sdata1_ff;

   // access stage, alongside the ram read data
   logic                             v2_ff;
   balsm_pkg::access_type            acc2_ff;

   // response register
   logic                             v3_ff;
   logic [balsm_pkg::DATA_W-1:0]     load_data3_ff;
   balsm_pkg::status_type            status3_ff;

   balsm_pkg::access_type            acc1;
   logic [AW-1:0]                    word_addr;
   logic [balsm_pkg::BYTE_LANES-1:0] lane_we;
   logic [balsm_pkg::DATA_W-1:0]     lane_wdata;
   logic [balsm_pkg::DATA_W-1:0]     rd_word;
   logic [balsm_pkg::DATA_W-1:0]     load_data2;

   assign en3 = !v3_ff || rsp_bus.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_bus.valid;
      end
      if (en1) begin
         op1_ff     <= req_bus.req_type;
         base1_ff   <= req_bus.base_address;
         offset1_ff <= req_bus.offset;
         sdata1_ff  <= req_bus.store_data;
      end
   end

   // address, range/alignment check and lane write control
   balsm_agen #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_agen (
      .op_raw       (op1_ff),
      .base_address (base1_ff),
      .offset       (offset1_ff),
      .store_data   (sdata1_ff),
      .access       (acc1),
      .word_addr    (word_addr),
      .lane_we      (lane_we),
      .lane_wdata   (lane_wdata)
   );

   // one ram per byte lane; a store commits only when its transfer moves on,
   // and read data is only captured when the access stage takes new data
   for (genvar k = 0; k < balsm_pkg::BYTE_LANES; k++) begin : g_lane
      balsm_ram #(
         .WIDTH (balsm_pkg::BYTE_W),
         .DEPTH (MEMORY_WORDS)
      ) u_ram (
         .clock (clock),
         .we    (v1_ff && en2 && lane_we[k]),
         .re    (en2),
         .addr  (word_addr),
         .wdata (lane_wdata[k*balsm_pkg::BYTE_W +: balsm_pkg::BYTE_W]),
         .rdata (rd_word[k*balsm_pkg::BYTE_W +: balsm_pkg::BYTE_W])
      );
   end

   // access stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         acc2_ff <= acc1;
      end
   end

   // lane select and extension
   balsm_ldfmt u_ldfmt (
      .access    (acc2_ff),
      .word      (rd_word),
      .load_data (load_data2)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         load_data3_ff <= load_data2;
         status3_ff    <= acc2_ff.status;
      end
   end

   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.load_data = load_data3_ff;
   assign rsp_bus.status    = status3_ff;

endmodule

// File: sv/balsm_ram.sv
// ----------------------------------------------------------------------------
// balsm_ram
// single port ram, write and read share one address, registered read data
// ----------------------------------------------------------------------------
module balsm_ram #(
   parameter int WIDTH = balsm_pkg::BYTE_W,
   parameter int DEPTH = balsm_pkg::MEMORY_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/balsm_agen.sv
// ----------------------------------------------------------------------------
// balsm_agen
// effective address, range and alignment check, byte lane write control
// ----------------------------------------------------------------------------
module balsm_agen #(
   parameter int MEMORY_WORDS = balsm_pkg::MEMORY_WORDS_DEFAULT
) (
   input  logic [balsm_pkg::OP_W-1:0]       op_raw,
   input  logic [balsm_pkg::DATA_W-1:0]     base_address,
   input  logic [balsm_pkg::DATA_W-1:0]     offset,
   input  logic [balsm_pkg::DATA_W-1:0]     store_data,
   output balsm_pkg::access_type            access,
   output logic [$clog2(MEMORY_WORDS)-1:0]  word_addr,
   output logic [balsm_pkg::BYTE_LANES-1:0] lane_we,
   output logic [balsm_pkg::DATA_W-1:0]     lane_wdata
);

   localparam int AW    = $clog2(MEMORY_WORDS);
   localparam int IDX_W = balsm_pkg::DATA_W - balsm_pkg::LANE_SEL_W;

   logic [balsm_pkg::DATA_W-1:0]     ea;
   logic [IDX_W-1:0]                 idx;
   logic [balsm_pkg::LANE_SEL_W-1:0] lane;
   logic                             in_range;
   balsm_pkg::op_type                op;

   assign ea       = base_address + offset;
   assign idx      = ea[balsm_pkg::DATA_W-1:balsm_pkg::LANE_SEL_W];
   assign lane     = ea[balsm_pkg::LANE_SEL_W-1:0];
   assign in_range = {{balsm_pkg::LANE_SEL_W{1'b0}}, idx} < balsm_pkg::DATA_W'(MEMORY_WORDS);
   assign op       = balsm_pkg::op_type'(op_raw);

   assign word_addr = idx[AW-1:0];

   always_comb begin
      access.op     = op;
      access.lane   = lane;
      access.status = balsm_pkg::ST_OK;
      lane_we       = '0;
      for (int k = 0; k < balsm_pkg::BYTE_LANES; k++) begin
         lane_wdata[k*balsm_pkg::BYTE_W +: balsm_pkg::BYTE_W] =
            (op == balsm_pkg::OP_SB) ? store_data[balsm_pkg::BYTE_W-1:0]
                                     : store_data[k*balsm_pkg::BYTE_W +: balsm_pkg::BYTE_W];
      end
      unique case (op)
         balsm_pkg::OP_LB, balsm_pkg::OP_LBU, balsm_pkg::OP_LW: begin
            if (!in_range) access.status = balsm_pkg::ST_RANGE;
         end
         balsm_pkg::OP_LH: begin
            if (!in_range)   access.status = balsm_pkg::ST_RANGE;
            else if (ea[0])  access.status = balsm_pkg::ST_ALIGN;
         end
         balsm_pkg::OP_SB: begin
            if (!in_range) access.status = balsm_pkg::ST_RANGE;
            else           lane_we[lane] = 1'b1;
         end
         balsm_pkg::OP_SW: begin
            if (!in_range) access.status = balsm_pkg::ST_RANGE;
            else           lane_we = '1;
         end
         default: begin
            // unused codes: no access, no check
         end
      endcase
   end

endmodule

// File: sv/balsm_ldfmt.sv
// ----------------------------------------------------------------------------
// balsm_ldfmt
// byte/halfword selection and extension of read data
// ----------------------------------------------------------------------------
module balsm_ldfmt (
   input  balsm_pkg::access_type        access,
   input  logic [balsm_pkg::DATA_W-1:0] word,
   output logic [balsm_pkg::DATA_W-1:0] load_data
);

   logic [balsm_pkg::BYTE_W-1:0] byte_sel;
   logic [balsm_pkg::HALF_W-1:0] half_sel;

   always_comb begin
      byte_sel = word[access.lane*balsm_pkg::BYTE_W +: balsm_pkg::BYTE_W];
      half_sel = access.lane[1] ? word[balsm_pkg::DATA_W-1:balsm_pkg::HALF_W]
                                : word[balsm_pkg::HALF_W-1:0];
      load_data = '0;
      if (access.status == balsm_pkg::ST_OK) begin
         unique case (access.op)
            balsm_pkg::OP_LB: load_data =
               {{(balsm_pkg::DATA_W-balsm_pkg::BYTE_W){byte_sel[balsm_pkg::BYTE_W-1]}}, byte_sel};
            balsm_pkg::OP_LBU: load_data =
               {{(balsm_pkg::DATA_W-balsm_pkg::BYTE_W){1'b0}}, byte_sel};
            balsm_pkg::OP_LH: load_data =
               {{(balsm_pkg::DATA_W-balsm_pkg::HALF_W){half_sel[balsm_pkg::HALF_W-1]}}, half_sel};
            balsm_pkg::OP_LW: load_data = word;
            default: load_data = '0;
         endcase
      end
   end

endmodule

// File: sv/balsm_checker.sv
// ----------------------------------------------------------------------------
// balsm_checker
// port level checks of the load/store memory unit, bound to the top level
// ----------------------------------------------------------------------------
module balsm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [balsm_pkg::DATA_W-1:0]   load_data,
   input logic [balsm_pkg::STATUS_W-1:0] status
);

   // transfers accepted but not yet answered
   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_valid && req_ready)  outstanding_in = outstanding_in + 3'd1;
      if (rsp_valid && rsp_ready)  outstanding_in = outstanding_in - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("response without an accepted request");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 3'd3)
      else $error("more transfers in flight than pipeline stages");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != balsm_pkg::ST_OK |-> load_data == '0)
      else $error("error response carries nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(load_data) && $stable(status))
      else $error("stalled response changed");

endmodule

bind byte_addressed_load_store_memory_unit balsm_checker u_balsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .load_data (rsp_bus.load_data),
   .status    (rsp_bus.status)
);

// File: tb/sv/byte_addressed_load_store_memory_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory_unit_tb
// drives loads and stores through the request channel, predicts responses from
// a shadow memory or a fixed row and checks every response transfer in order
// ----------------------------------------------------------------------------
module byte_addressed_load_store_memory_unit_tb;

   // memory size and derived byte span
   localparam int          MEM_WORDS  = balsm_pkg::MEMORY_WORDS_DEFAULT;
   localparam logic [31:0] BYTE_SPAN  = MEM_WORDS * balsm_pkg::BYTE_LANES;
   // words that most random traffic is aimed at, so loads find stored data
   localparam int          HOT_WORDS  = 64;

   // operation codes outside the enum, which the block must treat as no-ops
   localparam logic [balsm_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [balsm_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   // run shape
   localparam int RANDOM_ITEMS     = 900;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int LONG_HOLD_BURST  = 40;
   localparam int PAUSE_AT         = 450;
   localparam int BURST_FROM       = 600;
   localparam int BURST_LEN        = 100;
   localparam int DRAIN_CYCLES     = 10;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   typedef struct {
      logic [balsm_pkg::OP_W-1:0]          req_type;
      logic [balsm_pkg::DATA_W-1:0]        base_address;
      logic signed [balsm_pkg::DATA_W-1:0] offset;
      logic signed [balsm_pkg::DATA_W-1:0] store_data;
   } access_req_type;

   typedef struct {
      logic signed [balsm_pkg::DATA_W-1:0] load_data;
      balsm_pkg::status_type               status;
   } access_rsp_type;

   // one line of the directed table; fixed rows carry a hand-written response
   typedef struct {
      access_req_type req;
      bit             fixed;
      access_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   balsm_req_if req_bus ();
   balsm_rsp_if rsp_bus ();

   byte_addressed_load_store_memory_unit #(
      .MEMORY_WORDS(MEM_WORDS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // shadow of the memory contents and of which byte lanes hold stored data
   logic [balsm_pkg::DATA_W-1:0]     mem_image  [MEM_WORDS];
   logic [balsm_pkg::BYTE_LANES-1:0] lane_valid [MEM_WORDS];
   int unsigned                      stored_words[$];

   access_rsp_type   due_responses[$];
   directed_row_type directed_rows[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  long_hold_request = 1'b0;
   bit  no_idle = 1'b0;

   // ------------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // shadow starts clean; lanes count as stored only once a store has hit them
   initial begin
      for (int w = 0; w < MEM_WORDS; w++) begin
         mem_image[w]  = '0;
         lane_valid[w] = '0;
      end
   end

   // ------------------------------------------------------------------------
   // predictor: computes the response of one accepted access and applies its
   // effect on the shadow memory
   // ------------------------------------------------------------------------
   function automatic access_rsp_type load_store_result(input access_req_type r);
      access_rsp_type               res;
      logic [balsm_pkg::DATA_W-1:0] ea;
      logic [balsm_pkg::DATA_W-1:0] word;
      logic [balsm_pkg::DATA_W-1:0] shifted;
      int unsigned                  idx;
      logic [1:0]                   lane;
      res.load_data = '0;
      res.status    = balsm_pkg::ST_OK;
      ea   = r.base_address + r.offset;   // wraps modulo 2^32
      idx  = ea >> 2;
      lane = ea[1:0];
      // unused codes do nothing at all, not even the range check
      if (r.req_type <= balsm_pkg::OP_SW) begin
         if (idx >= MEM_WORDS) begin
            res.status = balsm_pkg::ST_RANGE;
         end else begin
            word = mem_image[idx];
            case (r.req_type)
               balsm_pkg::OP_LB: begin
                  shifted = word >> (8 * lane);
                  res.load_data = {{24{shifted[7]}}, shifted[7:0]};
               end
               balsm_pkg::OP_LBU: begin
                  shifted = word >> (8 * lane);
                  res.load_data = {24'h0, shifted[7:0]};
               end
               balsm_pkg::OP_LH: begin
                  if (ea[0]) begin
                     res.status = balsm_pkg::ST_ALIGN;
                  end else begin
                     shifted = word >> (16 * ea[1]);
                     res.load_data = {{16{shifted[15]}}, shifted[15:0]};
                  end
               end
               balsm_pkg::OP_LW: begin
                  res.load_data = word;
               end
               balsm_pkg::OP_SB: begin
                  if (lane_valid[idx] == '0) stored_words.push_back(idx);
                  mem_image[idx][8*lane +: 8] = r.store_data[7:0];
                  lane_valid[idx][lane] = 1'b1;
               end
               default: begin
                  if (lane_valid[idx] == '0) stored_words.push_back(idx);
                  mem_image[idx]  = r.store_data;
                  lane_valid[idx] = '1;
               end
            endcase
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // random access generator; loads only ever touch lanes already stored to
   // ------------------------------------------------------------------------
   function automatic access_req_type draw_access();
      access_req_type                   r;
      int unsigned                      pick;
      int unsigned                      word;
      int unsigned                      lane;
      int unsigned                      half;
      logic [balsm_pkg::DATA_W-1:0]     ea;
      logic [balsm_pkg::BYTE_LANES-1:0] mask;
      pick = $urandom_range(99);
      r.base_address = $urandom;
      r.store_data   = $urandom;
      r.req_type     = balsm_pkg::OP_SW;
      ea = '0;
      if (pick < 4) begin
         // unused codes with arbitrary address
         r.req_type = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
         ea = $urandom;
      end else if (pick < 14) begin
         // any real operation beyond the top of memory, often near the bound
         r.req_type = balsm_pkg::OP_W'($urandom_range(int'(balsm_pkg::OP_SW)));
         case ($urandom_range(3))
            0:       ea = BYTE_SPAN + $urandom_range(15);
            1:       ea = 32'hFFFF_FFFF - $urandom_range(15);
            default: ea = $urandom_range(32'hFFFF_FFFF, BYTE_SPAN);
         endcase
      end else if (pick < 50 || stored_words.size() == 0) begin
         // store, mostly into the hot region, now and then anywhere
         r.req_type = ($urandom_range(2) == 0) ? balsm_pkg::OP_SB : balsm_pkg::OP_SW;
         word = ($urandom_range(9) == 0) ? $urandom_range(MEM_WORDS - 1)
                                         : $urandom_range(HOT_WORDS - 1);
         ea = (word << 2) | $urandom_range(3);
      end else begin
         // load from a word that holds stored data
         word = stored_words[$urandom_range(stored_words.size() - 1)];
         mask = lane_valid[word];
         do lane = $urandom_range(3); while (!mask[lane]);
         r.req_type = ($urandom_range(1) == 0) ? balsm_pkg::OP_LB : balsm_pkg::OP_LBU;
         ea = (word << 2) | lane;
         case ($urandom_range(4))
            2: begin
               // aligned halfword, whichever half is complete
               half = $urandom_range(1);
               if (mask[2*half +: 2] != 2'b11) half = 1 - half;
               if (mask[2*half +: 2] == 2'b11) begin
                  r.req_type = balsm_pkg::OP_LH;
                  ea = (word << 2) | (half << 1);
               end
            end
            3: begin
               if (mask == '1) begin
                  r.req_type = balsm_pkg::OP_LW;
                  ea = (word << 2) | $urandom_range(3);
               end
            end
            4: begin
               // misaligned halfword, kept to fully stored words
               if (mask == '1) begin
                  r.req_type = balsm_pkg::OP_LH;
                  ea = (word << 2) | ($urandom_range(1) ? 2'd3 : 2'd1);
               end
            end
            default: ;
         endcase
      end
      // spread the address over base and offset so both see every bit
      r.offset = ea - r.base_address;
      return r;
   endfunction

   function automatic void add_row(input logic [balsm_pkg::OP_W-1:0] op,
                                   input logic [balsm_pkg::DATA_W-1:0] base,
                                   input logic signed [balsm_pkg::DATA_W-1:0] offs,
                                   input logic signed [balsm_pkg::DATA_W-1:0] data,
                                   input bit fixed = 1'b0,
                                   input logic [balsm_pkg::DATA_W-1:0] want_data = '0,
                                   input balsm_pkg::status_type want_status =
                                      balsm_pkg::ST_OK);
      directed_row_type row;
      row.req.req_type     = op;
      row.req.base_address = base;
      row.req.offset       = offs;
      row.req.store_data   = data;
      row.fixed            = fixed;
      row.rsp.load_data    = want_data;
      row.rsp.status       = want_status;
      directed_rows.push_back(row);
   endfunction

   // one request transfer: optional idle gap, then offer until accepted
   task automatic send_access(input access_req_type r, input int unsigned gap);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= r.req_type;
      req_bus.base_address <= r.base_address;
      req_bus.offset       <= r.offset;
      req_bus.store_data   <= r.store_data;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic flag_mismatch(input string what,
                                input logic [balsm_pkg::DATA_W-1:0] want,
                                input logic [balsm_pkg::DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // ------------------------------------------------------------------------
   // request side: directed table, then random traffic
   // ------------------------------------------------------------------------
   initial begin : request_source
      access_req_type r;
      access_rsp_type predicted;
      int unsigned    gap;

      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= '0;
      req_bus.base_address <= '0;
      req_bus.offset       <= '0;
      req_bus.store_data   <= '0;

      // word zero: every lane, both signs of byte and halfword
      add_row(balsm_pkg::OP_SW,  32'h0000_0000, 0, 32'h80FF_7F01, 1'b1, '0,
              balsm_pkg::ST_OK);
      add_row(balsm_pkg::OP_LB,  32'h0000_0000, 0, 0);
      add_row(balsm_pkg::OP_LB,  32'h0000_0010, -13, 0);
      add_row(balsm_pkg::OP_LBU, 32'h0000_0003, 0, 0);
      add_row(balsm_pkg::OP_LH,  32'h0000_0000, 2, 0);
      add_row(balsm_pkg::OP_LH,  32'h0000_0000, 0, 0);
      // odd halfword addresses
      add_row(balsm_pkg::OP_LH,  32'h0000_0001, 0, 0, 1'b1, '0, balsm_pkg::ST_ALIGN);
      add_row(balsm_pkg::OP_LH,  32'h0000_0000, 3, 0, 1'b1, '0, balsm_pkg::ST_ALIGN);
      // word access ignores the low address bits
      add_row(balsm_pkg::OP_LW,  32'h0000_0002, -1, 0);
      add_row(balsm_pkg::OP_SB,  32'h0000_0000, 1, 32'hFFFF_FFAA, 1'b1, '0,
              balsm_pkg::ST_OK);
      add_row(balsm_pkg::OP_LW,  32'h0000_0000, 0, 0);
      // top word, reached through wrap of base plus offset
      add_row(balsm_pkg::OP_SW,  32'hFFFF_FFFF, 32'h0000_3FFD, 32'h7FFF_FFFF, 1'b1, '0,
              balsm_pkg::ST_OK);
      add_row(balsm_pkg::OP_LW,  32'h0000_3FFF, 0, 0);
      add_row(balsm_pkg::OP_LBU, BYTE_SPAN, -1, 0);
      // out of range for word and byte operations; a store there writes nothing
      add_row(balsm_pkg::OP_SW,  BYTE_SPAN, 0, 32'hDEAD_BEEF, 1'b1, '0,
              balsm_pkg::ST_RANGE);
      add_row(balsm_pkg::OP_LW,  32'h0000_0000, BYTE_SPAN, 0, 1'b1, '0,
              balsm_pkg::ST_RANGE);
      add_row(balsm_pkg::OP_LB,  32'hFFFF_FFFF, 0, 0, 1'b1, '0, balsm_pkg::ST_RANGE);
      add_row(balsm_pkg::OP_LBU, 32'h0000_0000, -1, 0, 1'b1, '0, balsm_pkg::ST_RANGE);
      // odd and out of range: range wins; then byte and word stores out of range
      add_row(balsm_pkg::OP_LH,  32'h8000_0001, 0, 0, 1'b1, '0, balsm_pkg::ST_RANGE);
      add_row(balsm_pkg::OP_SB,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0,
              balsm_pkg::ST_RANGE);
      add_row(balsm_pkg::OP_SW,  32'h0000_0010, 32'h8000_0000, 0, 1'b1, '0,
              balsm_pkg::ST_RANGE);
      // unused codes: no check, no write
      add_row(OP_RSVD6, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0,
              balsm_pkg::ST_OK);
      add_row(OP_RSVD7, 32'h0000_0000, 32'h8000_0000, 0, 1'b1, '0, balsm_pkg::ST_OK);
      // words stored to above, which the out of range rows must leave untouched
      add_row(balsm_pkg::OP_LW,  BYTE_SPAN - 4, 0, 0);
      add_row(balsm_pkg::OP_LW,  32'h0000_0000, 0, 0);

      do @(posedge clock); while (reset);

      foreach (directed_rows[i]) begin
         send_access(directed_rows[i].req, $urandom_range(5));
         predicted = load_store_result(directed_rows[i].req);
         due_responses.push_back(directed_rows[i].fixed ? directed_rows[i].rsp
                                                        : predicted);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // response side holds off while requests keep coming back to back
         if (n == LONG_HOLD_AT) long_hold_request = 1'b1;
         // let the pipeline drain completely once
         if (n == PAUSE_AT) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (due_responses.size() != 0);
         end
         no_idle = (n >= BURST_FROM) && (n < BURST_FROM + BURST_LEN);
         r = draw_access();
         if (no_idle || (n >= LONG_HOLD_AT && n < LONG_HOLD_AT + LONG_HOLD_BURST))
            gap = 0;
         else
            gap = $urandom_range(5);
         send_access(r, gap);
         due_responses.push_back(load_store_result(r));
      end
      req_bus.valid <= 1'b0;
      no_idle = 1'b0;

      // wait for the last responses, then give stray ones a chance to show
      do @(posedge clock); while (due_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && due_responses.size() == 0) begin
         $display("PASS byte_addressed_load_store_memory_unit");
      end else begin
         $display("FAIL byte_addressed_load_store_memory_unit");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random stalls per transfer, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : response_sink
      int unsigned hold;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            hold = no_idle ? 0 : $urandom_range(5);
            if (hold != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // ------------------------------------------------------------------------
   // response check: each transfer against the oldest due response
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      access_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_responses.size() == 0) begin
            flag_mismatch("response with none due", '0, rsp_bus.load_data);
         end else begin
            want = due_responses.pop_front();
            if (rsp_bus.load_data !== want.load_data)
               flag_mismatch("load_data", want.load_data, rsp_bus.load_data);
            if (rsp_bus.status !== want.status)
               flag_mismatch("status", 32'(want.status), 32'(rsp_bus.status));
         end
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL byte_addressed_load_store_memory_unit");
         $finish;
      end
   end

endmodule
